// ===== design/fmt6_pkg.sv =====
// shared types, constants and helper functions for the ipv6 text formatter
`timescale 1ns / 1ps

package fmt6_pkg;

   // address layout
   localparam int GROUP_COUNT = 8;
   localparam int GROUP_WIDTH = 16;
   localparam int HALF_WIDTH  = 64;
   localparam int CHAR_WIDTH  = 7;

   // ascii codes
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 7'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_COLON = 7'h3a;

   // default depth of the queue between front and back
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   // one classified address as it travels through the queue
   typedef struct packed {
      logic [HALF_WIDTH-1:0] addr_high;
      logic [HALF_WIDTH-1:0] addr_low;
      logic                  skip_en;
      logic [2:0]            skip_first;
      logic [2:0]            skip_resume;
   } fmt6_entry_type;

   // back-end status seen by the top level
   typedef struct packed {
      logic busy;
      logic emit_last;
   } fmt6_back_status_type;

   // pick one 16-bit group, group 0 in the top bits of the high half
   function automatic logic [GROUP_WIDTH-1:0] group_of(
      input logic [HALF_WIDTH-1:0] hi,
      input logic [HALF_WIDTH-1:0] lo,
      input logic [2:0]            idx
   );
      logic [HALF_WIDTH-1:0]  half;
      logic [GROUP_WIDTH-1:0] grp;
      half = idx[2] ? lo : hi;
      unique case (idx[1:0])
         2'd0: grp = half[63:48];
         2'd1: grp = half[47:32];
         2'd2: grp = half[31:16];
         2'd3: grp = half[15:0];
      endcase
      return grp;
   endfunction

   // lowercase hex digit
   function automatic logic [CHAR_WIDTH-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_WIDTH-1:0] ch;
      if (nib < 4'd10) begin
         ch = CHAR_ZERO + CHAR_WIDTH'(nib);
      end else begin
         ch = CHAR_A + CHAR_WIDTH'(nib - 4'd10);
      end
      return ch;
   endfunction

endpackage

// ===== design/fmt6_front.sv =====
// front end: accepts addresses and locates the zero run to compress
`timescale 1ns / 1ps

module fmt6_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [63:0]              req_addr_high,
   input  logic [63:0]              req_addr_low,
   input  logic                     q_full,
   output logic                     q_push,
   output fmt6_pkg::fmt6_entry_type q_data
);
   import fmt6_pkg::*;

   logic [GROUP_COUNT-1:0] zero_grp;
   logic                   skip_en;
   logic [2:0]             skip_first;
   logic [2:0]             skip_resume;

   // per-group zero flags
   always_comb begin
      for (int i = 0; i < GROUP_COUNT; i++) begin
         zero_grp[i] = (group_of(req_addr_high, req_addr_low, 3'(i)) == '0);
      end
   end

   // first zero group among groups 1..6 opens the compression
   always_comb begin
      skip_en    = 1'b0;
      skip_first = 3'd0;
      for (int i = 1; i < GROUP_COUNT - 1; i++) begin
         if (!skip_en && zero_grp[i]) begin
            skip_en    = 1'b1;
            skip_first = 3'(i);
         end
      end
   end

   // first nonzero group after the run, never past the last group
   always_comb begin
      skip_resume = 3'(GROUP_COUNT - 1);
      for (int j = GROUP_COUNT - 2; j >= 2; j--) begin
         if (skip_en && (3'(j) > skip_first) && !zero_grp[j]) begin
            skip_resume = 3'(j);
         end
      end
   end

   // push classified entry into the queue
   assign req_stall          = q_full;
   assign q_push             = req_valid && !q_full;
   assign q_data.addr_high   = req_addr_high;
   assign q_data.addr_low    = req_addr_low;
   assign q_data.skip_en     = skip_en;
   assign q_data.skip_first  = skip_first;
   assign q_data.skip_resume = skip_resume;

endmodule

// ===== design/fmt6_queue.sv =====
// short fifo of classified addresses between front and back
`timescale 1ns / 1ps

module fmt6_queue #(
   parameter int DEPTH = fmt6_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  fmt6_pkg::fmt6_entry_type             push_data,
   input  logic                                 pop,
   output fmt6_pkg::fmt6_entry_type             pop_data,
   output logic                                 full,
   output logic                                 empty,
   output logic [$clog2(DEPTH+1)-1:0]           count
);
   import fmt6_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fmt6_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entries_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

// ===== design/fmt6_back.sv =====
// back end: sequences the characters of one address, one per cycle while the output is not stalled
`timescale 1ns / 1ps

module fmt6_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  fmt6_pkg::fmt6_entry_type       q_data,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [6:0]                     rsp_out_char,
   output logic                           rsp_last_char,
   output fmt6_pkg::fmt6_back_status_type status
);
   import fmt6_pkg::*;

   // character position within a group
   localparam logic [2:0] POS_COLON  = 3'd0;
   localparam logic [2:0] POS_COLON2 = 3'd1;
   localparam logic [2:0] POS_DIG0   = 3'd2;
   localparam logic [2:0] POS_DIG1   = 3'd3;
   localparam logic [2:0] POS_DIG2   = 3'd4;
   localparam logic [2:0] POS_DIG3   = 3'd5;

   localparam logic [2:0] LAST_GROUP = 3'(GROUP_COUNT - 1);

   fmt6_entry_type        ent_ff, ent_in;
   logic                  busy_ff, busy_in;
   logic [2:0]            cur_ff, cur_in;
   logic [2:0]            pos_ff, pos_in;
   logic                  dbl_ff, dbl_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_WIDTH-1:0] out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;

   logic [GROUP_WIDTH-1:0] grp;
   logic [3:0]             nib;
   logic [CHAR_WIDTH-1:0]  ch;
   logic                   fire;
   logic                   emit_last;

   // current character
   always_comb begin
      grp = group_of(ent_ff.addr_high, ent_ff.addr_low, cur_ff);
      unique case (pos_ff)
         POS_DIG0: nib = grp[15:12];
         POS_DIG1: nib = grp[11:8];
         POS_DIG2: nib = grp[7:4];
         POS_DIG3: nib = grp[3:0];
         default:  nib = 4'd0;
      endcase
      if (pos_ff == POS_COLON || pos_ff == POS_COLON2) begin
         ch = CHAR_COLON;
      end else begin
         ch = hex_char(nib);
      end
   end

   assign emit_last = (pos_ff == POS_DIG3) && (cur_ff == LAST_GROUP);
   assign fire      = busy_ff && (!out_valid_ff || !rsp_stall);
   assign q_pop     = !q_empty && (!busy_ff || (fire && emit_last));

   // sequencer
   always_comb begin
      ent_in  = ent_ff;
      busy_in = busy_ff;
      cur_in  = cur_ff;
      pos_in  = pos_ff;
      dbl_in  = dbl_ff;
      if (fire) begin
         unique case (pos_ff)
            POS_COLON:  pos_in = dbl_ff ? POS_COLON2 : POS_DIG0;
            POS_COLON2: begin
               pos_in = POS_DIG0;
               dbl_in = 1'b0;
            end
            POS_DIG0:   pos_in = POS_DIG1;
            POS_DIG1:   pos_in = POS_DIG2;
            POS_DIG2:   pos_in = POS_DIG3;
            POS_DIG3: begin
               if (cur_ff == LAST_GROUP) begin
                  busy_in = 1'b0;
               end else begin
                  pos_in = POS_COLON;
                  if (ent_ff.skip_en && (cur_ff + 3'd1 == ent_ff.skip_first)) begin
                     cur_in = ent_ff.skip_resume;
                     dbl_in = 1'b1;
                  end else begin
                     cur_in = cur_ff + 3'd1;
                  end
               end
            end
            default:    pos_in = POS_DIG0;
         endcase
      end
      // load next address, also right after the final character
      if (q_pop) begin
         ent_in  = q_data;
         busy_in = 1'b1;
         cur_in  = 3'd0;
         pos_in  = POS_DIG0;
         dbl_in  = 1'b0;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         out_char_in  = ch;
         out_last_in  = emit_last;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cur_ff       <= 3'd0;
         pos_ff       <= POS_DIG0;
         dbl_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cur_ff       <= cur_in;
         pos_ff       <= pos_in;
         dbl_ff       <= dbl_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff      <= ent_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_char     = out_char_ff;
   assign rsp_last_char    = out_last_ff;
   assign status.busy      = busy_ff;
   assign status.emit_last = emit_last;

endmodule

// ===== design/format_ipv6_address_text.sv =====
// top level: ipv6 address to text formatter, one character per transfer
// throughput: one character per cycle while the output is not stalled, 10 to 39 characters per address, set by
//    the back-end character sequencer; the next address loads as the last char goes out
// a new address passes a queue entry, the sequencer entry register and the output register in turn
// the front classifies and queues up to QUEUE_DEPTH addresses while the back works
// reset: synchronous, active high; empties the queue and drops any address in work
`timescale 1ns / 1ps

module format_ipv6_address_text #(
   parameter int QUEUE_DEPTH = fmt6_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_addr_high,
   input  logic [63:0] req_addr_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_out_char,
   output logic        rsp_last_char
);
   import fmt6_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   fmt6_entry_type       push_data;
   fmt6_entry_type       pop_data;
   fmt6_back_status_type back_status;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_full;
   logic                 q_empty;
   logic [CNT_W-1:0]     q_count;

   // classify and enqueue
   fmt6_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_addr_high (req_addr_high),
      .req_addr_low  (req_addr_low),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (push_data)
   );

   // decoupling queue
   fmt6_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty),
      .count     (q_count)
   );

   // character sequencer
   fmt6_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (pop_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .status        (back_status)
   );

   // queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CNT_W'(QUEUE_DEPTH))
      else $error("queue overfilled");

   // the final character of an address is always a hex digit
   a_last_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> rsp_out_char != CHAR_COLON)
      else $error("last character is a colon");

   // a taken non-final character means the sequencer still owns that address
   a_busy_mid_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_char |-> back_status.busy)
      else $error("sequencer idle in the middle of an address");

   // nothing leaves the block right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
